// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the ordered record list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every rising clock edge outside reset.
`define ORLE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle leads to another in the next cycle.
`define ORLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/orle_pkg.sv =====
// Shared types, codes and constants of the ordered record list engine.
package orle_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int IN_TDATA_W  = 200;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 200;
  localparam int OUT_TUSER_W = 2;
  localparam int TOTAL_W     = 5;
  localparam int POS_W       = 5;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_END   = 3'd1;
  localparam logic [2:0] OP_DEL_FRONT = 3'd2;
  localparam logic [2:0] OP_DEL_END   = 3'd3;
  localparam logic [2:0] OP_DEL_POS   = 3'd4;
  localparam logic [2:0] OP_LIST      = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam logic [1:0] CMD_INS_FRONT = 2'd0;
  localparam logic [1:0] CMD_INS_END   = 2'd1;
  localparam logic [1:0] CMD_DEL_AT    = 2'd2;
  localparam logic [1:0] CMD_ROTATE    = 2'd3;

  typedef struct packed {
    logic [31:0]        name_part2;
    logic [63:0]        name_part1;
    logic [63:0]        name_part0;
    logic signed [31:0] roll;
  } rec_t;

  typedef struct packed {
    logic       en;
    logic [1:0] cmd;
  } cell_ctl_t;

endpackage

// ===== hdl/ordered_record_list_engine_unit.sv =====
// Ordered record list engine top level: command decode, list sequencer and cell chain.
// Holds up to CAPACITY records (roll number plus a 20-byte name) in a row of cells,
// head in cell 0. Insert and delete requests give one result each: a front insert or
// a delete shifts the cells from the affected one onward by one place, an end insert
// writes the cell after the tail, and an end delete only lowers the count. A list
// request gives one result per stored entry from head to tail (one empty-status result
// if empty), one per cycle while out_tready is high, by rotating the chain one place
// per result; after the final result the chain is back in order. Requests are taken
// only when idle and the output register is empty or drains in the same cycle.
module ordered_record_list_engine_unit #(
  parameter int CAPACITY = orle_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // position, new_roll, new_name_part0, new_name_part1, new_name_part2, zero fill
  input  logic [orle_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic [orle_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // entry_total, roll, name_part0, name_part1, name_part2, zero fill
  output logic [orle_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [orle_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                             out_tlast
);

  `include "assert_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + orle_pkg::POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic                              state_r, state_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [CW-1:0]                     k_r, k_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [1:0]                        out_status_r, out_status_nxt;
  logic [CW-1:0]                     out_count_r, out_count_nxt;
  orle_pkg::rec_t                    out_rec_r, out_rec_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              out_free;
  logic                              acc;
  logic [2:0]                        op;
  logic [orle_pkg::POS_W-1:0]        pos;
  logic [XW-1:0]                     pos_x;
  logic [XW-1:0]                     count_x;
  logic [XW-1:0]                     pos_m1_x;
  logic [XW-1:0]                     total_x;
  logic                              is_full;
  logic                              is_empty;
  logic                              pos_bad;
  logic                              list_last;
  logic                              full_ins;
  orle_pkg::rec_t                    new_rec;
  orle_pkg::cell_ctl_t               ctl;
  logic [CW-1:0]                     sel;
  orle_pkg::rec_t                    cell_q [CAPACITY];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;

  assign op                 = in_tuser[2:0];
  assign pos                = in_tdata[4:0];
  assign new_rec.roll       = in_tdata[36:5];
  assign new_rec.name_part0 = in_tdata[100:37];
  assign new_rec.name_part1 = in_tdata[164:101];
  assign new_rec.name_part2 = in_tdata[196:165];

  assign pos_x     = {{CW{1'b0}}, pos};
  assign count_x   = {{orle_pkg::POS_W{1'b0}}, count_r};
  assign pos_m1_x  = pos_x - XW'(1);
  assign is_full   = (count_r == CAP_C);
  assign is_empty  = (count_r == '0);
  assign pos_bad   = (pos == '0) || (pos_x > count_x);
  assign list_last = (k_r == (count_r - ONE_C));
  assign full_ins  = acc && is_full &&
                     ((op == orle_pkg::OP_INS_FRONT) || (op == orle_pkg::OP_INS_END));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_rec_nxt    = out_rec_r;
    out_last_nxt   = out_last_r;
    ctl            = '0;
    sel            = count_r;

    if (state_r == S_IDLE) begin
      if (acc) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = orle_pkg::ST_OK;
        out_rec_nxt    = '0;
        out_last_nxt   = 1'b1;
        case (op)
          orle_pkg::OP_INS_FRONT, orle_pkg::OP_INS_END: begin
            if (is_full) begin
              out_status_nxt = orle_pkg::ST_FULL;
            end else begin
              ctl.en    = 1'b1;
              ctl.cmd   = (op == orle_pkg::OP_INS_FRONT) ? orle_pkg::CMD_INS_FRONT
                                                         : orle_pkg::CMD_INS_END;
              count_nxt = count_r + ONE_C;
            end
          end
          orle_pkg::OP_DEL_FRONT: begin
            if (is_empty) begin
              out_status_nxt = orle_pkg::ST_EMPTY;
            end else begin
              ctl.en    = 1'b1;
              ctl.cmd   = orle_pkg::CMD_DEL_AT;
              sel       = '0;
              count_nxt = count_r - ONE_C;
            end
          end
          orle_pkg::OP_DEL_END: begin
            if (is_empty) out_status_nxt = orle_pkg::ST_EMPTY;
            else          count_nxt      = count_r - ONE_C;
          end
          orle_pkg::OP_DEL_POS: begin
            if (is_empty) begin
              out_status_nxt = orle_pkg::ST_EMPTY;
            end else if (pos_bad) begin
              out_status_nxt = orle_pkg::ST_BADPOS;
            end else begin
              ctl.en    = 1'b1;
              ctl.cmd   = orle_pkg::CMD_DEL_AT;
              sel       = pos_m1_x[CW-1:0];
              count_nxt = count_r - ONE_C;
            end
          end
          orle_pkg::OP_LIST: begin
            if (is_empty) begin
              out_status_nxt = orle_pkg::ST_EMPTY;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_LIST;
              k_nxt         = '0;
            end
          end
          default: out_status_nxt = orle_pkg::ST_OK;
        endcase
        out_count_nxt = count_nxt;
      end
    end else begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = orle_pkg::ST_OK;
        out_count_nxt  = count_r;
        out_rec_nxt    = cell_q[0];
        out_last_nxt   = list_last;
        ctl.en         = 1'b1;
        ctl.cmd        = orle_pkg::CMD_ROTATE;
        sel            = count_r - ONE_C;
        k_nxt          = k_r + ONE_C;
        if (list_last) state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_rec_r    <= out_rec_nxt;
    out_last_r   <= out_last_nxt;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    orle_pkg::rec_t left_rec;
    orle_pkg::rec_t right_rec;
    if (g == 0) begin : g_head
      assign left_rec = new_rec;
    end else begin : g_body
      assign left_rec = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_rec = cell_q[g];
    end else begin : g_mid
      assign right_rec = cell_q[g+1];
    end
    orle_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sel       (sel),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .new_rec   (new_rec),
      .wrap_rec  (cell_q[0]),
      .rec       (cell_q[g])
    );
  end

  assign total_x    = {{orle_pkg::POS_W{1'b0}}, out_count_r};
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_rec_r.name_part2, out_rec_r.name_part1,
                       out_rec_r.name_part0, out_rec_r.roll,
                       total_x[orle_pkg::TOTAL_W-1:0]};

  `ORLE_ASSERT_ALWAYS(a_count_bound, count_r <= CAP_C, "entry count above capacity")
  `ORLE_ASSERT_ALWAYS(a_list_nonempty, (state_r != S_LIST) || (count_r != '0), "empty list walk")
  `ORLE_ASSERT_NEXT(a_list_count_hold, state_r == S_LIST, $stable(count_r), "count moved in list")
  `ORLE_ASSERT_NEXT(a_full_hold, full_ins, $stable(count_r), "full insert changed count")

endmodule

// ===== hdl/orle_cell.sv =====
// One cell of the record chain: holds one record and moves it per chain command.
module orle_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  orle_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]       sel,
  input  orle_pkg::rec_t      left_rec,
  input  orle_pkg::rec_t      right_rec,
  input  orle_pkg::rec_t      new_rec,
  input  orle_pkg::rec_t      wrap_rec,
  output orle_pkg::rec_t      rec
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  orle_pkg::rec_t data_r;
  orle_pkg::rec_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.en) begin
      case (ctl.cmd)
        orle_pkg::CMD_INS_FRONT: data_nxt = left_rec;
        orle_pkg::CMD_INS_END: begin
          if (MY_IDX == sel) data_nxt = new_rec;
        end
        orle_pkg::CMD_DEL_AT: begin
          if (MY_IDX >= sel) data_nxt = right_rec;
        end
        orle_pkg::CMD_ROTATE: data_nxt = (MY_IDX == sel) ? wrap_rec : right_rec;
        default: data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign rec = data_r;

endmodule

// ===== bench/orle_checker.sv =====
// Checker for the ordered record list engine: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module orle_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [orle_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [orle_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [orle_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [orle_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                             out_tlast,
  output int                               fail_count,
  output int                               pending,
  output int                               checked
);

  localparam int CAP = orle_pkg::CAPACITY_DEF;
  localparam int TW  = orle_pkg::TOTAL_W;
  localparam int PW  = orle_pkg::POS_W;

  typedef struct {
    logic [1:0]     status;
    logic [TW-1:0]  total;
    orle_pkg::rec_t rec;
    logic           last;
  } list_reply_t;

  orle_pkg::rec_t rows [CAP];
  int unsigned    level;
  list_reply_t    replies_due [$];
  int             errors_n;
  int             checked_n;

  initial begin
    level     = 0;
    errors_n  = 0;
    checked_n = 0;
  end

  function automatic void push_reply(logic [1:0] st, int slot, logic lst);
    list_reply_t e;
    e.status = st;
    e.total  = level[TW-1:0];
    e.rec    = (slot >= 0) ? rows[slot] : '0;
    e.last   = lst;
    replies_due.push_back(e);
  endfunction

  function automatic void drop_row(int unsigned idx);
    for (int unsigned i = idx; i + 1 < level; i++) rows[i] = rows[i + 1];
    level = level - 1;
  endfunction

  function automatic void predict_reply(logic [2:0] op, logic [PW-1:0] pos,
                                        orle_pkg::rec_t r);
    case (op)
      orle_pkg::OP_INS_FRONT, orle_pkg::OP_INS_END: begin
        if (level >= CAP) begin
          push_reply(orle_pkg::ST_FULL, -1, 1'b1);
        end else begin
          if (op == orle_pkg::OP_INS_FRONT) begin
            for (int unsigned i = level; i > 0; i--) rows[i] = rows[i - 1];
            rows[0] = r;
          end else begin
            rows[level] = r;
          end
          level = level + 1;
          push_reply(orle_pkg::ST_OK, -1, 1'b1);
        end
      end
      orle_pkg::OP_DEL_FRONT, orle_pkg::OP_DEL_END, orle_pkg::OP_DEL_POS: begin
        if (level == 0) begin
          push_reply(orle_pkg::ST_EMPTY, -1, 1'b1);
        end else if (op == orle_pkg::OP_DEL_FRONT) begin
          drop_row(0);
          push_reply(orle_pkg::ST_OK, -1, 1'b1);
        end else if (op == orle_pkg::OP_DEL_END) begin
          level = level - 1;
          push_reply(orle_pkg::ST_OK, -1, 1'b1);
        end else if (pos == 0 || pos > level) begin
          push_reply(orle_pkg::ST_BADPOS, -1, 1'b1);
        end else begin
          drop_row(pos - 1);
          push_reply(orle_pkg::ST_OK, -1, 1'b1);
        end
      end
      orle_pkg::OP_LIST: begin
        if (level == 0) begin
          push_reply(orle_pkg::ST_EMPTY, -1, 1'b1);
        end else begin
          for (int i = 0; i < level; i++) push_reply(orle_pkg::ST_OK, i, (i + 1) == level);
        end
      end
      default: begin
        push_reply(orle_pkg::ST_OK, -1, 1'b1);
      end
    endcase
  endfunction

  function automatic int field_diff(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    list_reply_t    want;
    orle_pkg::rec_t got;
    int             bad;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        checked_n = checked_n + 1;
        if (replies_due.size() == 0) begin
          $error("result with no request waiting: status %0h total %0h",
                 out_tuser, out_tdata[TW-1:0]);
          errors_n = errors_n + 1;
        end else begin
          want = replies_due.pop_front();
          got  = out_tdata[TW +: $bits(orle_pkg::rec_t)];
          bad  = 0;
          bad += field_diff("status", 64'(want.status), 64'(out_tuser));
          bad += field_diff("entry_total", 64'(want.total), 64'(out_tdata[TW-1:0]));
          bad += field_diff("roll", 64'(want.rec.roll), 64'(got.roll));
          bad += field_diff("name_part0", want.rec.name_part0, got.name_part0);
          bad += field_diff("name_part1", want.rec.name_part1, got.name_part1);
          bad += field_diff("name_part2", 64'(want.rec.name_part2), 64'(got.name_part2));
          bad += field_diff("last", 64'(want.last), 64'(out_tlast));
          if (bad != 0) errors_n = errors_n + 1;
        end
      end
      if (in_tvalid && in_tready) begin
        predict_reply(in_tuser, in_tdata[PW-1:0], in_tdata[PW +: $bits(orle_pkg::rec_t)]);
      end
    end
    fail_count <= errors_n;
    pending    <= replies_due.size();
    checked    <= checked_n;
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the ordered record list engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int CAP     = orle_pkg::CAPACITY_DEF;
  localparam int PW      = orle_pkg::POS_W;
  localparam int N_ITEMS = 500;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [orle_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [orle_pkg::IN_TUSER_W-1:0]  in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [orle_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [orle_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                             out_tlast;

  int fail_count;
  int pending;
  int checked;

  int level;
  int sent;
  int req_by_op [8];
  bit choke_req;
  bit choke_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ordered_record_list_engine_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  orle_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic orle_pkg::rec_t rand_rec();
    orle_pkg::rec_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 11))
      0: r = '0;
      1: r = '1;
      2: r.roll = 32'sh8000_0000;
      3: r.roll = 32'sh7fff_ffff;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_req(input logic [2:0] op, input int pos, input orle_pkg::rec_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, r, PW'(pos)};
    do @(posedge clk); while (!in_tready);
    sent = sent + 1;
    req_by_op[op] = req_by_op[op] + 1;
    case (op)
      orle_pkg::OP_INS_FRONT, orle_pkg::OP_INS_END: if (level < CAP) level = level + 1;
      orle_pkg::OP_DEL_FRONT, orle_pkg::OP_DEL_END: if (level > 0) level = level - 1;
      orle_pkg::OP_DEL_POS: if (level > 0 && pos != 0 && pos <= level) level = level - 1;
      default: ;
    endcase
  endtask

  task automatic send_delete();
    int k;
    k = $urandom_range(0, 2);
    if (k == 0) send_req(orle_pkg::OP_DEL_FRONT, $urandom_range(0, 16), rand_rec());
    else if (k == 1) send_req(orle_pkg::OP_DEL_END, $urandom_range(0, 16), rand_rec());
    else send_req(orle_pkg::OP_DEL_POS, (level > 0) ? $urandom_range(1, level) : 1,
                  rand_rec());
  endtask

  task automatic send_mixed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) send_req(($urandom_range(0, 1) != 0) ? orle_pkg::OP_INS_END
                                                     : orle_pkg::OP_INS_FRONT,
                         $urandom_range(0, 16), rand_rec());
    else if (r < 75) send_delete();
    else if (r < 85) send_req(orle_pkg::OP_DEL_POS, ($urandom_range(0, 1) != 0) ? 0 :
                              $urandom_range((level < 16) ? level + 1 : 16, 16), rand_rec());
    else if (r < 95) send_req(orle_pkg::OP_LIST, $urandom_range(0, 16), rand_rec());
    else send_req(3'($urandom_range(6, 7)), $urandom_range(0, 16), rand_rec());
  endtask

  // receiver side: random ready bursts, one long hold-off on request
  initial begin : rx_drive
    int hi;
    int g;
    out_tready <= 1'b0;
    choke_done = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (choke_req && !choke_done) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        choke_done = 1'b1;
      end
      out_tready <= 1'b1;
      hi = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 20);
      repeat (hi) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("ordered_record_list_engine_unit test failed");
    $finish;
  end

  initial begin : stimulus
    orle_pkg::rec_t r;
    int             ep;
    level     = 0;
    sent      = 0;
    choke_req = 1'b0;
    foreach (req_by_op[i]) req_by_op[i] = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, unused codes, extreme records, bad positions
    send_req(orle_pkg::OP_LIST, 0, rand_rec());
    send_req(orle_pkg::OP_DEL_FRONT, 0, rand_rec());
    send_req(orle_pkg::OP_DEL_END, 0, rand_rec());
    send_req(orle_pkg::OP_DEL_POS, 1, rand_rec());
    send_req(3'd6, 31, '1);
    send_req(3'd7, 0, '0);
    r = '1;
    r.roll = 32'sh8000_0000;
    send_req(orle_pkg::OP_INS_FRONT, 0, r);
    r = '0;
    r.roll = 32'sh7fff_ffff;
    send_req(orle_pkg::OP_INS_END, 31, r);
    send_req(orle_pkg::OP_INS_FRONT, 16, rand_rec());
    send_req(orle_pkg::OP_LIST, 0, rand_rec());
    send_req(orle_pkg::OP_DEL_POS, 0, rand_rec());
    send_req(orle_pkg::OP_DEL_POS, 4, rand_rec());
    send_req(orle_pkg::OP_DEL_POS, 16, rand_rec());
    send_req(orle_pkg::OP_DEL_POS, 2, rand_rec());
    send_req(orle_pkg::OP_DEL_END, 0, rand_rec());
    send_req(orle_pkg::OP_INS_END, 0, '1);
    send_req(orle_pkg::OP_LIST, 0, rand_rec());
    send_req(orle_pkg::OP_DEL_FRONT, 0, rand_rec());
    send_req(orle_pkg::OP_DEL_FRONT, 0, rand_rec());
    send_req(orle_pkg::OP_LIST, 0, rand_rec());

    choke_req = 1'b1;
    while (sent < N_ITEMS + 20) begin
      ep = $urandom_range(0, 9);
      if (ep < 2) begin
        repeat ($urandom_range(2, 18))
          send_req(($urandom_range(0, 1) != 0) ? orle_pkg::OP_INS_END
                                               : orle_pkg::OP_INS_FRONT,
                   $urandom_range(0, 16), rand_rec());
        if ($urandom_range(0, 1) != 0) send_req(orle_pkg::OP_LIST, 0, rand_rec());
      end else if (ep == 2) begin
        repeat (level + $urandom_range(0, 2)) send_delete();
      end else if (ep == 3) begin
        send_req(orle_pkg::OP_LIST, $urandom_range(0, 16), rand_rec());
      end else begin
        repeat ($urandom_range(3, 10)) send_mixed();
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d requests: %0d inserts, %0d deletes, %0d lists, %0d unused codes",
             sent, req_by_op[orle_pkg::OP_INS_FRONT] + req_by_op[orle_pkg::OP_INS_END],
             req_by_op[orle_pkg::OP_DEL_FRONT] + req_by_op[orle_pkg::OP_DEL_END] +
             req_by_op[orle_pkg::OP_DEL_POS],
             req_by_op[orle_pkg::OP_LIST], req_by_op[6] + req_by_op[7]);
    $display("Checked %0d results under random stalls and one long output hold-off",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("ordered_record_list_engine_unit test passed");
    end else begin
      $display("ordered_record_list_engine_unit test failed");
    end
    $finish;
  end

endmodule
